// ===== rtl/core/rfw_pkg.sv =====
// Package for the multiquadric forward warp block.
// Shared widths, table depth, command and status structs. No dependencies.
package rfw_pkg;
    localparam int MaxPoints = 16;
    localparam int IdxW      = $clog2(MaxPoints);
    localparam int CntW      = $clog2(MaxPoints + 1);
    localparam int CoordW    = 12;
    localparam int RadW      = 24;
    localparam int WgtW      = 32;
    localparam int ColW      = 24;
    localparam int QW        = 50;   // radius^2 + d2<<16 fits in 50 bits
    localparam int SW        = 25;   // floor(sqrt(q))
    localparam int AccW      = 64;
    localparam int SizeCap   = 4096;

    localparam logic [1:0] CfgPointCount  = 2'd0;
    localparam logic [1:0] CfgImageWidth  = 2'd1;
    localparam logic [1:0] CfgImageHeight = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic            load_px;   // clear accumulators
        logic            rd_en;     // read table entry
        logic [IdxW-1:0] rd_idx;
        logic            d2_en;     // form q from table read
        logic            sq_start;  // start square root
        logic            mul_en;    // multiply s by weights
        logic            acc_en;    // accumulate products
        logic            finish;    // final truncation and bounds check
    } t_rfw_cmd;

    // datapath -> controller
    typedef struct packed {
        logic sq_done;
    } t_rfw_sts;
endpackage

// ===== rtl/core/rfw_isqrt.sv =====
// Iterative integer square root, two radicand bits per cycle.
// Uses rfw_pkg widths.
module rfw_isqrt (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [rfw_pkg::QW-1:0]   i_q,
    output logic                     o_done,
    output logic [rfw_pkg::SW-1:0]   o_s
);
    localparam int Steps = rfw_pkg::SW;
    localparam int StW   = $clog2(Steps + 1);

    logic [rfw_pkg::QW-1:0] r_rem;
    logic [rfw_pkg::QW-1:0] r_val;
    logic [rfw_pkg::SW-1:0] r_root;
    logic [StW-1:0]         r_cnt;
    logic                   r_busy;
    logic                   r_done;

    logic [rfw_pkg::SW+1:0] trial;
    logic [rfw_pkg::SW+1:0] rem_sh;

    // next remainder with two more radicand bits
    always_comb begin
        rem_sh = {r_rem[rfw_pkg::SW-1:0], r_val[rfw_pkg::QW-1 -: 2]};
        trial  = {r_root, 2'b01};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= StW'(Steps);
                r_rem  <= '0;
                r_root <= '0;
                r_val  <= i_q;
            end else if (r_busy) begin
                r_val <= r_val << 2;
                if (rem_sh >= trial) begin
                    r_rem  <= rfw_pkg::QW'(rem_sh - trial);
                    r_root <= {r_root[rfw_pkg::SW-2:0], 1'b1};
                end else begin
                    r_rem  <= rfw_pkg::QW'(rem_sh);
                    r_root <= {r_root[rfw_pkg::SW-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == StW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_s    = r_root;
endmodule

// ===== rtl/core/rfw_datapath.sv =====
// Datapath: control point table, distance, square root, multiply, sums, bounds.
// Depends on rfw_pkg and rfw_isqrt.
module rfw_datapath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  rfw_pkg::t_rfw_cmd            i_cmd,
    output rfw_pkg::t_rfw_sts            o_sts,
    input  logic                         i_wr_en,
    input  logic [rfw_pkg::IdxW-1:0]     i_wr_idx,
    input  logic [rfw_pkg::CoordW-1:0]   i_anchor_x,
    input  logic [rfw_pkg::CoordW-1:0]   i_anchor_y,
    input  logic [rfw_pkg::RadW-1:0]     i_radius,
    input  logic signed [rfw_pkg::WgtW-1:0] i_weight_x,
    input  logic signed [rfw_pkg::WgtW-1:0] i_weight_y,
    input  logic                         i_px_load,
    input  logic [rfw_pkg::CoordW-1:0]   i_pixel_x,
    input  logic [rfw_pkg::CoordW-1:0]   i_pixel_y,
    input  logic [rfw_pkg::ColW-1:0]     i_pixel_color,
    input  logic [12:0]                  i_width,
    input  logic [12:0]                  i_height,
    output logic                         o_valid,
    output logic [rfw_pkg::CoordW-1:0]   o_dest_x,
    output logic [rfw_pkg::CoordW-1:0]   o_dest_y,
    output logic [rfw_pkg::ColW-1:0]     o_dest_color
);
    localparam int Tw = rfw_pkg::CoordW*2 + rfw_pkg::RadW + rfw_pkg::WgtW*2;

    // one memory holds all entry fields
    logic [Tw-1:0] r_mem [rfw_pkg::MaxPoints];
    logic [Tw-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= {i_anchor_x, i_anchor_y, i_radius, i_weight_x, i_weight_y};
        end
        if (i_cmd.rd_en) begin
            r_rd <= r_mem[i_cmd.rd_idx];
        end
    end

    logic [rfw_pkg::CoordW-1:0] t_ax, t_ay;
    logic [rfw_pkg::RadW-1:0]   t_r;
    logic [rfw_pkg::WgtW-1:0]   t_wx, t_wy;
    assign {t_ax, t_ay, t_r, t_wx, t_wy} = r_rd;

    // pixel latch
    logic [rfw_pkg::CoordW-1:0] r_px, r_py;
    logic [rfw_pkg::ColW-1:0]   r_col;

    // squared distance terms
    logic signed [rfw_pkg::CoordW:0] ex, ey;
    logic [25:0]                     n_d2;
    logic [47:0]                     n_r2;
    logic [rfw_pkg::QW-1:0]          r_q;
    logic signed [rfw_pkg::WgtW-1:0] r_wx, r_wy, r_wx2, r_wy2;

    always_comb begin
        ex   = $signed({1'b0, r_px}) - $signed({1'b0, t_ax});
        ey   = $signed({1'b0, r_py}) - $signed({1'b0, t_ay});
        n_d2 = 26'(ex * ex) + 26'(ey * ey);
        n_r2 = t_r * t_r;
    end

    logic                     sq_done;
    logic [rfw_pkg::SW-1:0]   sq_s;

    // pixel fields are taken at the accepting edge itself
    always_ff @(posedge i_clk) begin
        if (i_px_load) begin
            r_px  <= i_pixel_x;
            r_py  <= i_pixel_y;
            r_col <= i_pixel_color;
        end
        if (i_cmd.d2_en) begin
            r_q  <= rfw_pkg::QW'(n_r2) + rfw_pkg::QW'({n_d2, 16'd0});
            r_wx <= t_wx;
            r_wy <= t_wy;
        end
        if (i_cmd.sq_start) begin
            r_wx2 <= r_wx;
            r_wy2 <= r_wy;
        end
    end

    rfw_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.sq_start),
        .i_q     (r_q),
        .o_done  (sq_done),
        .o_s     (sq_s)
    );
    assign o_sts.sq_done = sq_done;

    // products and sums
    logic signed [57:0] r_prx, r_pry;
    logic signed [rfw_pkg::AccW-1:0] r_accx, r_accy;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prx <= r_wx2 * $signed({1'b0, sq_s});
            r_pry <= r_wy2 * $signed({1'b0, sq_s});
        end
        if (i_cmd.load_px) begin
            r_accx <= '0;
            r_accy <= '0;
        end else if (i_cmd.acc_en) begin
            r_accx <= r_accx + rfw_pkg::AccW'(r_prx);
            r_accy <= r_accy + rfw_pkg::AccW'(r_pry);
        end
    end

    // final add, truncation toward zero, bounds check
    logic signed [rfw_pkg::AccW-1:0] tx, ty;
    logic signed [39:0] dx, dy;
    logic [12:0] wcap, hcap;

    function automatic logic signed [39:0] trunc24(input logic signed [63:0] v);
        logic [63:0] mag;
        begin
            mag = v[63] ? 64'(-v) : 64'(v);
            trunc24 = v[63] ? -$signed({1'b0, mag[62:24]}) : $signed({1'b0, mag[62:24]});
        end
    endfunction

    always_comb begin
        tx   = r_accx + $signed({28'd0, r_px, 24'd0});
        ty   = r_accy + $signed({28'd0, r_py, 24'd0});
        dx   = trunc24(tx);
        dy   = trunc24(ty);
        wcap = (i_width  > 13'(rfw_pkg::SizeCap)) ? 13'(rfw_pkg::SizeCap) : i_width;
        hcap = (i_height > 13'(rfw_pkg::SizeCap)) ? 13'(rfw_pkg::SizeCap) : i_height;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_cmd.finish && dx > 0 && dy > 0
                       && dx < $signed({27'd0, wcap}) && dy < $signed({27'd0, hcap});
        end
        o_dest_x     <= dx[11:0];
        o_dest_y     <= dy[11:0];
        o_dest_color <= r_col;
    end
endmodule

// ===== rtl/core/rfw_ctrl.sv =====
// Controller: walks the loaded points one at a time through the datapath.
// Depends on rfw_pkg.
module rfw_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_go,
    input  logic [rfw_pkg::CntW-1:0]   i_count,
    input  rfw_pkg::t_rfw_sts          i_sts,
    output rfw_pkg::t_rfw_cmd          o_cmd,
    output logic                       o_busy
);
    typedef enum logic [2:0] {
        ST_IDLE, ST_READ, ST_DIST, ST_SQRT, ST_MUL, ST_ACC, ST_FIN
    } t_state;

    t_state                    r_state;
    logic [rfw_pkg::CntW-1:0]  r_k;
    logic [rfw_pkg::CntW-1:0]  r_n;
    rfw_pkg::t_rfw_cmd         r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_k     <= '0;
            r_n     <= '0;
            r_cmd   <= '0;
        end else begin
            r_cmd <= '0;
            unique case (r_state)
                ST_IDLE: begin
                    if (i_go) begin
                        r_cmd.load_px <= 1'b1;
                        r_k           <= '0;
                        r_n           <= i_count;
                        r_state       <= (i_count == '0) ? ST_FIN : ST_READ;
                    end
                end
                ST_READ: begin
                    r_cmd.rd_en  <= 1'b1;
                    r_cmd.rd_idx <= r_k[rfw_pkg::IdxW-1:0];
                    r_state      <= ST_DIST;
                end
                ST_DIST: begin
                    r_cmd.d2_en <= 1'b1;
                    r_state     <= ST_SQRT;
                end
                ST_SQRT: begin
                    if (!r_cmd.sq_start && !r_cmd.d2_en && r_k[rfw_pkg::CntW-1] == 1'b0
                        && i_sts.sq_done) begin
                        r_cmd.mul_en <= 1'b1;
                        r_state      <= ST_MUL;
                    end else if (r_cmd.d2_en) begin
                        r_cmd.sq_start <= 1'b1;
                    end
                end
                ST_MUL: begin
                    r_cmd.acc_en <= 1'b1;
                    r_state      <= ST_ACC;
                end
                ST_ACC: begin
                    r_k     <= r_k + 1'b1;
                    r_state <= (r_k + 1'b1 == r_n) ? ST_FIN : ST_READ;
                end
                ST_FIN: begin
                    r_cmd.finish <= (r_n != '0);
                    r_state      <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_cmd  = r_cmd;
    assign o_busy = (r_state != ST_IDLE) || r_cmd.finish;
endmodule

// ===== rtl/core/rbf_forward_warp_eval.sv =====
// Top level of the multiquadric forward warp block.
// Depends on rfw_pkg, rfw_ctrl, rfw_datapath.
//
// Usage: an item is taken when start is high and busy low. Mode 0
// loads one control point into the table. Mode 1 warps a pixel: each
// used point takes a table read, a distance step, a square root (start,
// 25 steps, done), a multiply and an accumulate, one point at a time.
// With N = min(point_count, 16) busy stays high through the final step
// of the pixel, the result strobe, if any, follows in the next cycle,
// and the next item can be taken in that cycle. All points share the
// one square root unit. When N is not 0 and the destination lies
// strictly inside the image, o_valid pulses one cycle with o_dest_x,
// o_dest_y and o_dest_color; otherwise no transaction appears. The
// receiver cannot stall the result. Configuration writes (i_cfg_we,
// i_cfg_idx, i_cfg_data) take effect at once; the user must make them
// only while idle, as the block does not enforce this. Reset sets
// point_count 0, width 640, height 480; the table is undefined until
// loaded.
module rbf_forward_warp_eval (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [12:0] i_cfg_data,
    input  logic        start,
    output logic        busy,
    input  logic        i_mode,
    input  logic [3:0]  i_entry_index,
    input  logic [11:0] i_anchor_x,
    input  logic [11:0] i_anchor_y,
    input  logic [23:0] i_radius,
    input  logic signed [31:0] i_weight_x,
    input  logic signed [31:0] i_weight_y,
    input  logic [11:0] i_pixel_x,
    input  logic [11:0] i_pixel_y,
    input  logic [23:0] i_pixel_color,
    output logic        o_valid,
    output logic [11:0] o_dest_x,
    output logic [11:0] o_dest_y,
    output logic [23:0] o_dest_color
);
    logic [4:0]  r_point_count;
    logic [12:0] r_image_width, r_image_height;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count  <= 5'd0;
            r_image_width  <= 13'd640;
            r_image_height <= 13'd480;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rfw_pkg::CfgPointCount:  r_point_count  <= i_cfg_data[4:0];
                rfw_pkg::CfgImageWidth:  r_image_width  <= i_cfg_data;
                rfw_pkg::CfgImageHeight: r_image_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic accept, go, wr_en;
    logic [rfw_pkg::CntW-1:0] cnt;
    rfw_pkg::t_rfw_cmd cmd;
    rfw_pkg::t_rfw_sts sts;

    assign accept = start && !busy;
    assign go     = accept && i_mode;
    assign wr_en  = accept && !i_mode;
    assign cnt    = (r_point_count > 5'(rfw_pkg::MaxPoints))
                    ? rfw_pkg::CntW'(rfw_pkg::MaxPoints) : rfw_pkg::CntW'(r_point_count);

    rfw_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (go),
        .i_count (cnt),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    rfw_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_wr_en       (wr_en),
        .i_wr_idx      (i_entry_index),
        .i_anchor_x    (i_anchor_x),
        .i_anchor_y    (i_anchor_y),
        .i_radius      (i_radius),
        .i_weight_x    (i_weight_x),
        .i_weight_y    (i_weight_y),
        .i_px_load     (go),
        .i_pixel_x     (i_pixel_x),
        .i_pixel_y     (i_pixel_y),
        .i_pixel_color (i_pixel_color),
        .i_width       (r_image_width),
        .i_height      (r_image_height),
        .o_valid       (o_valid),
        .o_dest_x      (o_dest_x),
        .o_dest_y      (o_dest_y),
        .o_dest_color  (o_dest_color)
    );

    // a result only follows the final step of a pixel
    a_valid_after_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(cmd.finish)) else $error("result without finish");
    // a result never lands on the zero row or column of the image
    a_in_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_dest_x != 12'd0 && o_dest_y != 12'd0))
        else $error("result on image border");
    // no accumulate without a multiply before it
    a_acc_after_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.acc_en |-> $past(cmd.mul_en)) else $error("accumulate out of order");
endmodule
